[rtl/arlc_pkg.sv]
// ----------------------------------------------------------------------------
// arlc_pkg: shared types, constants and functions for the response line
// classifier
// Holds the keyword tables, the per-line state record and the per-character
// update and line classification functions.
// ----------------------------------------------------------------------------
`default_nettype none

package arlc_pkg;

  // Byte codes
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_PROMPT = 8'h3E;
  localparam logic [7:0] CHAR_ONE    = 8'h31;

  // Register reset values
  localparam logic [7:0] END_CHAR_RESET    = 8'h0A;
  localparam logic [7:0] MARKER_CHAR_RESET = 8'hFF;

  // Configuration port
  localparam int unsigned CFG_INDEX_W = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_END_CHAR    = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_MARKER_CHAR = CFG_INDEX_W'(1);

  // Line position saturates here; it also sizes the keyword table rows
  localparam int unsigned POS_W = 4;
  localparam logic [POS_W-1:0] POS_MAX = '1;
  localparam logic [POS_W-1:0] POS_SIXTH   = POS_W'(5);
  localparam logic [POS_W-1:0] POS_SEVENTH = POS_W'(6);

  // Keywords, bit positions in the alive mask
  localparam int unsigned NUM_KW     = 5;
  localparam int unsigned KW_OK      = 0;
  localparam int unsigned KW_ERROR   = 1;
  localparam int unsigned KW_IPD     = 2;
  localparam int unsigned KW_ALREADY = 3;
  localparam int unsigned KW_SENDOK  = 4;

  localparam logic [7:0] KW_TEXT [NUM_KW][16] = '{
    '{0: "O", 1: "K", default: 8'h00},
    '{0: "E", 1: "R", 2: "R", 3: "O", 4: "R", default: 8'h00},
    '{0: "+", 1: "I", 2: "P", 3: "D", default: 8'h00},
    '{0: "A", 1: "L", 2: "R", 3: "E", 4: "A", 5: "D", 6: "Y", 7: "C",
      8: "O", 9: "N", 10: "N", 11: "E", 12: "C", 13: "T", default: 8'h00},
    '{0: "S", 1: "E", 2: "N", 3: "D", 4: "O", 5: "K", default: 8'h00}
  };

  localparam logic [POS_W-1:0] KW_LEN [NUM_KW] = '{
    POS_W'(2), POS_W'(5), POS_W'(4), POS_W'(14), POS_W'(6)
  };

  typedef enum logic [2:0] {
    CLASS_NONE    = 3'd0,
    CLASS_OK      = 3'd1,
    CLASS_ERROR   = 3'd2,
    CLASS_PROMPT  = 3'd3,
    CLASS_CONFIG  = 3'd4,
    CLASS_ALREADY = 3'd5,
    CLASS_SENDOK  = 3'd6
  } line_class_t;

  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [NUM_KW-1:0] alive;
    logic              first_is_prompt;
    logic              sixth_is_one;
    logic [7:0]        seventh_char;
  } line_state_t;

  typedef struct packed {
    logic        marker_seen;
    line_class_t line_class;
    logic        line_done;
    logic [7:0]  config_byte;
  } line_result_t;

  localparam line_state_t LINE_CLEAR = '{
    pos: '0, alive: '1, first_is_prompt: 1'b0, sixth_is_one: 1'b0,
    seventh_char: 8'h00
  };

  // Add one character to the line
  function automatic line_state_t absorb(line_state_t s, logic [7:0] c);
    line_state_t r;
    r = s;
    for (int k = 0; k < NUM_KW; k++) begin
      if (s.pos < KW_LEN[k] && KW_TEXT[k][s.pos] != c) begin
        r.alive[k] = 1'b0;
      end
    end
    if (s.pos == '0 && c == CHAR_PROMPT) r.first_is_prompt = 1'b1;
    if (s.pos == POS_SIXTH) r.sixth_is_one = (c == CHAR_ONE);
    if (s.pos == POS_SEVENTH) r.seventh_char = c;
    if (s.pos != POS_MAX) r.pos = s.pos + POS_W'(1);
    return r;
  endfunction

  function automatic logic kw_hit(line_state_t s, int unsigned k);
    return s.alive[k] && (s.pos >= KW_LEN[k]);
  endfunction

  // Classify a finished line by prefix, in priority order
  function automatic line_result_t classify(line_state_t s);
    line_result_t r;
    r = '{marker_seen: 1'b0, line_class: CLASS_NONE, line_done: 1'b1,
          config_byte: 8'h00};
    if (kw_hit(s, KW_OK)) begin
      r.line_class = CLASS_OK;
    end else if (kw_hit(s, KW_ERROR)) begin
      r.line_class = CLASS_ERROR;
    end else if (s.first_is_prompt) begin
      r.line_class = CLASS_PROMPT;
    end else if (kw_hit(s, KW_IPD)) begin
      if (s.sixth_is_one) begin
        r.line_class  = CLASS_CONFIG;
        r.config_byte = s.seventh_char;
      end
    end else if (kw_hit(s, KW_ALREADY)) begin
      r.line_class = CLASS_ALREADY;
    end else if (kw_hit(s, KW_SENDOK)) begin
      r.line_class = CLASS_SENDOK;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/arlc_line.sv]
// ----------------------------------------------------------------------------
// arlc_line: line tracker
// Keeps the state of the line being received, folds in one byte per request
// and produces the result for that byte combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module arlc_line
  import arlc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         take,
  input  wire logic [7:0]   rx_byte,
  input  wire logic [7:0]   end_char,
  input  wire logic [7:0]   marker_char,
  output line_result_t      result
);

  line_state_t line;
  line_state_t line_next;

  // Decode the byte and work out the new line state and the result
  always_comb begin
    line_state_t one;
    line_state_t two;
    one = absorb(line, rx_byte);
    two = absorb(one, end_char);
    line_next = line;
    result    = '{marker_seen: 1'b0, line_class: CLASS_NONE, line_done: 1'b0,
                  config_byte: 8'h00};
    if (rx_byte == marker_char) begin
      result.marker_seen = 1'b1;
    end else if (rx_byte != CHAR_SPACE && rx_byte != CHAR_CR) begin
      if (rx_byte == end_char) begin
        result    = classify(one);
        line_next = LINE_CLEAR;
      end else if (rx_byte == CHAR_PROMPT) begin
        // prompt ends the line at once, with an implied end character
        result    = classify(two);
        line_next = LINE_CLEAR;
      end else begin
        line_next = one;
      end
    end
  end

  // Advance the line state on each request
  always_ff @(posedge clk) begin
    if (rst) begin
      line <= LINE_CLEAR;
    end else if (take) begin
      line <= line_next;
    end
  end

endmodule

`default_nettype wire

[rtl/at_response_line_classifier.sv]
// ----------------------------------------------------------------------------
// at_response_line_classifier: modem response line classifier
// Sorts received modem bytes into response lines and reports each line's kind.
// ----------------------------------------------------------------------------
// The block takes one received byte per cycle while the skid stage is free and
// returns one result per byte; prefix match and line classification are
// combinational logic in front of the output register, or the skid register
// while the output is held. A two-entry output stage (register plus skid) keeps
// the input side taking bytes while a result waits, so the sustained rate is
// one byte per cycle whenever the downstream side takes results every cycle.
// The user writes end and marker characters through the configuration port only
// while no byte is in flight, unenforced; unknown register indexes are ignored.
`default_nettype none

module at_response_line_classifier
  import arlc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  // configuration writes
  input  wire logic                   cfg_valid,
  output      logic                   cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [7:0]             cfg_data,
  // received bytes
  input  wire logic                   s_tvalid,
  output      logic                   s_tready,
  input  wire logic [7:0]             s_tdata,  // [7:0] rx_byte
  // results
  output      logic                   m_tvalid,
  input  wire logic                   m_tready,
  output      logic [7:0]             m_tdata,  // [7:0] config_byte
  output      logic                   m_tlast,  // line_done
  output      logic [3:0]             m_tuser   // [2:0] line_class, [3] marker_seen
);

  logic [7:0]   end_char;
  logic [7:0]   marker_char;
  logic         take;
  line_result_t new_result;
  line_result_t out_data;
  line_result_t skid_data;
  logic         out_valid;
  logic         skid_valid;

  // Hold the configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      end_char    <= END_CHAR_RESET;
      marker_char <= MARKER_CHAR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_END_CHAR:    end_char    <= cfg_data;
        REG_MARKER_CHAR: marker_char <= cfg_data;
        default: ;
      endcase
    end
  end

  // Take a request whenever the skid stage is free
  assign s_tready = !skid_valid;
  assign take     = s_tvalid && s_tready;

  arlc_line u_line (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .rx_byte     (s_tdata),
    .end_char    (end_char),
    .marker_char (marker_char),
    .result      (new_result)
  );

  // Output register and skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (m_tready) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (take) begin
      if (!out_valid || m_tready) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (m_tready) out_data <= skid_data;
    end else if (take) begin
      if (!out_valid || m_tready) begin
        out_data <= new_result;
      end else begin
        skid_data <= new_result;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data.config_byte;
  assign m_tlast  = out_data.line_done;
  assign m_tuser  = {out_data.marker_seen, out_data.line_class};

  // Checks
  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage full while output register empty");

  a_take_gives_result: assert property (@(posedge clk) disable iff (rst)
    (take && !out_valid) |=> m_tvalid)
    else $error("taken byte produced no result");

  a_class_needs_done: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> (m_tuser[2:0] == CLASS_NONE))
    else $error("line class reported without a finished line");

  a_config_only_for_class: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[2:0] != CLASS_CONFIG) |-> (m_tdata == 8'h00))
    else $error("config byte set outside config class");

endmodule

`default_nettype wire
